// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pattern run decoder.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/prd_pkg.sv =====
// Package of the pattern run decoder: sizes, phase and status codes, and the
// structs passed between the control logic and the top level. No dependencies.
package prd_pkg;

	localparam int BUF_DEPTH = 4096;
	localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	// fill and read indexes must hold BUF_DEPTH itself
	localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
	localparam int REP_W     = 31;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PATTERN,
		PH_OUTPUT,
		PH_ENDED,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		ST_ACCEPT  = 3'd0,
		ST_REFUSE  = 3'd1,
		ST_DELIVER = 3'd2,
		ST_NONE    = 3'd3,
		ST_END     = 3'd4,
		ST_TOOLONG = 3'd5
	} status_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		status_t status;
		logic    last;
		logic    deliver;
	} result_t;

endpackage

// ===== hw/rtl/prd_if.sv =====
// Valid/ready channel interfaces of the pattern run decoder: the command
// channel and the result channel. No dependencies.
interface prd_cmd_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] stream_byte;

	modport source (output valid, output command, output stream_byte, input ready);
	modport sink (input valid, input command, input stream_byte, output ready);
endinterface

interface prd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] status;
	logic       last_of_record;

	modport source (output valid, output out_byte, output status, output last_of_record,
		input ready);
	modport sink (input valid, input out_byte, input status, input last_of_record,
		output ready);
endinterface

// ===== hw/rtl/prd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module prd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/prd_ctrl.sv =====
// Control of the pattern run decoder: header capture, phase machine, fill
// and read indexes, pattern store port requests. Depends on prd_pkg.
module prd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic              command,
	input  logic [7:0]        stream_byte,
	output prd_pkg::ram_wr_t  wr,
	output prd_pkg::ram_rd_t  rd,
	output prd_pkg::result_t  res
);

	prd_pkg::phase_t             phase_q, phase_d;
	logic [2:0]                  hcnt_q, hcnt_d;
	logic [63:0]                 hdr_q, hdr_d;
	logic [prd_pkg::LEN_W-1:0]   len_q, len_d;
	logic [prd_pkg::REP_W-1:0]   cnt_q, cnt_d;
	logic                        cnt_pos_q, cnt_pos_d;
	logic [prd_pkg::LEN_W-1:0]   fill_q, fill_d;
	logic [prd_pkg::LEN_W-1:0]   rdi_q, rdi_d;
	logic [prd_pkg::REP_W-1:0]   rep_q, rep_d;

	logic [63:0]                 hdr_nx;
	logic [31:0]                 cnt32, len32;
	logic                        cnt_gt0, len_gt0, len_big;
	logic [prd_pkg::LEN_W-1:0]   fill_nx, rdi_nx;
	logic [prd_pkg::REP_W-1:0]   rep_nx;

	// decode the header as it would stand after this byte
	assign hdr_nx  = {stream_byte, hdr_q[63:8]};
	assign cnt32   = hdr_nx[31:0];
	assign len32   = hdr_nx[63:32];
	assign cnt_gt0 = !cnt32[31] && (cnt32 != 32'd0);
	assign len_gt0 = !len32[31] && (len32 != 32'd0);
	assign len_big = !len32[31] && (len32 > 32'(prd_pkg::BUF_DEPTH));
	assign fill_nx = fill_q + prd_pkg::LEN_W'(1);
	assign rdi_nx  = rdi_q + prd_pkg::LEN_W'(1);
	assign rep_nx  = rep_q + prd_pkg::REP_W'(1);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= prd_pkg::PH_HEADER;
			hcnt_q    <= '0;
			hdr_q     <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			cnt_pos_q <= 1'b0;
			fill_q    <= '0;
			rdi_q     <= '0;
			rep_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			hcnt_q    <= hcnt_d;
			hdr_q     <= hdr_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			cnt_pos_q <= cnt_pos_d;
			fill_q    <= fill_d;
			rdi_q     <= rdi_d;
			rep_q     <= rep_d;
		end
	end

	// next state, store requests and result of the accepted beat
	always_comb begin
		phase_d     = phase_q;
		hcnt_d      = hcnt_q;
		hdr_d       = hdr_q;
		len_d       = len_q;
		cnt_d       = cnt_q;
		cnt_pos_d   = cnt_pos_q;
		fill_d      = fill_q;
		rdi_d       = rdi_q;
		rep_d       = rep_q;
		wr.we       = 1'b0;
		wr.addr     = fill_q[prd_pkg::ADDR_W-1:0];
		wr.data     = stream_byte;
		rd.re       = 1'b0;
		rd.addr     = rdi_q[prd_pkg::ADDR_W-1:0];
		res.status  = prd_pkg::ST_ACCEPT;
		res.last    = 1'b0;
		res.deliver = 1'b0;
		if (acc) begin
			unique case (phase_q)
				prd_pkg::PH_ERROR: begin
					res.status = prd_pkg::ST_TOOLONG;
				end
				prd_pkg::PH_ENDED: begin
					res.status = prd_pkg::ST_END;
				end
				prd_pkg::PH_HEADER: begin
					if (command) begin
						res.status = prd_pkg::ST_NONE;
					end else begin
						// shift in one header byte
						hdr_d  = hdr_nx;
						hcnt_d = hcnt_q + 3'd1;
						if (hcnt_q == 3'd7) begin
							hcnt_d = 3'd0;
							priority if (!cnt_gt0 && !len_gt0) begin
								phase_d    = prd_pkg::PH_ENDED;
								res.status = prd_pkg::ST_END;
							end else if (len_big) begin
								phase_d    = prd_pkg::PH_ERROR;
								res.status = prd_pkg::ST_TOOLONG;
							end else if (len_gt0) begin
								len_d     = len32[prd_pkg::LEN_W-1:0];
								cnt_d     = cnt32[prd_pkg::REP_W-1:0];
								cnt_pos_d = cnt_gt0;
								fill_d    = '0;
								phase_d   = prd_pkg::PH_PATTERN;
							end else begin
								// empty record: next byte opens a new header
								phase_d = prd_pkg::PH_HEADER;
							end
						end
					end
				end
				prd_pkg::PH_PATTERN: begin
					if (command) begin
						res.status = prd_pkg::ST_NONE;
					end else begin
						// store one pattern byte
						wr.we  = 1'b1;
						fill_d = fill_nx;
						if (fill_nx >= len_q) begin
							rdi_d   = '0;
							rep_d   = '0;
							hcnt_d  = 3'd0;
							phase_d = cnt_pos_q ? prd_pkg::PH_OUTPUT : prd_pkg::PH_HEADER;
						end
					end
				end
				prd_pkg::PH_OUTPUT: begin
					if (!command) begin
						res.status = prd_pkg::ST_REFUSE;
					end else begin
						// read one pattern byte, advance position and repeat
						rd.re       = 1'b1;
						res.status  = prd_pkg::ST_DELIVER;
						res.deliver = 1'b1;
						rdi_d       = rdi_nx;
						if (rdi_nx >= len_q) begin
							rdi_d = '0;
							rep_d = rep_nx;
							if (rep_nx >= cnt_q) begin
								res.last = 1'b1;
								rep_d    = '0;
								hcnt_d   = 3'd0;
								phase_d  = prd_pkg::PH_HEADER;
							end
						end
					end
				end
				default: begin
					phase_d = prd_pkg::PH_HEADER;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/pattern_run_decoder_top.sv =====
// Pattern run decoder top level: one result beat for every command beat, in the cycle
// after acceptance; sustains one command per cycle while the result side is ready. The
// pattern store's read is registered, and its data lands with the result register.
// Reset clears the phase, counters and result valid flag at once; the pattern
// store has no clearing pass and is written before it is read.
// Depends on prd_pkg, prd_if, prd_ram, prd_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module pattern_run_decoder_top (
	input logic         clk,
	input logic         arst_n,
	prd_cmd_if.sink     cmd_ch,
	prd_res_if.source   res_ch
);

	logic              acc;
	logic              v_s1;
	prd_pkg::result_t  res;
	prd_pkg::result_t  res_s1;
	prd_pkg::ram_wr_t  wr;
	prd_pkg::ram_rd_t  rd;
	logic [7:0]        rdata;

	// take a beat whenever the result register is free or drains this cycle
	assign cmd_ch.ready = !v_s1 || res_ch.ready;
	assign acc          = cmd_ch.valid && cmd_ch.ready;

	prd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.command     (cmd_ch.command),
		.stream_byte (cmd_ch.stream_byte),
		.wr          (wr),
		.rd          (rd),
		.res         (res)
	);

	prd_ram #(
		.WIDTH (8),
		.DEPTH (prd_pkg::BUF_DEPTH),
		.AW    (prd_pkg::ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (rdata)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (res_ch.ready) begin
			v_s1 <= 1'b0;
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	assign res_ch.valid          = v_s1;
	assign res_ch.status         = res_s1.status;
	assign res_ch.last_of_record = res_s1.last;
	assign res_ch.out_byte       = res_s1.deliver ? rdata : 8'd0;

	// store is never written and read in the same beat
	`ASSERT_ALWAYS(a_no_rw_overlap, clk, arst_n, !(wr.we && rd.re))
	// a store read is followed by a delivered result
	`ASSERT_NEXT(a_read_delivers, clk, arst_n, rd.re,
		v_s1 && res_s1.deliver && (res_s1.status == prd_pkg::ST_DELIVER))
	// end of record only marks a delivered byte
	`ASSERT_IMPLY(a_last_is_deliver, clk, arst_n, res_ch.valid && res_ch.last_of_record,
		res_ch.status == prd_pkg::ST_DELIVER)

endmodule

// ===== verif/pattern_run_decoder_top_test.sv =====
// Self-checking testbench of pattern_run_decoder_top: a queue-fed driver, a result monitor
// and a beat-level mirror of the decoder that predicts every result beat.
// Depends on prd_pkg, prd_if and the decoder RTL.
`timescale 1ns / 1ps

module pattern_run_decoder_top_test;
	import prd_pkg::*;

	localparam bit CMD_PUSH = 1'b0;
	localparam bit CMD_PULL = 1'b1;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int RUNAWAY_PULLS = 300;
	localparam int STICKY_ITEMS  = 24;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		bit         command;
		logic [7:0] stream_byte;
	} cmd_beat_t;

	typedef struct {
		logic [7:0] out_byte;
		status_t    status;
		logic       last;
	} decoded_t;

	logic clk;
	logic arst_n;

	prd_cmd_if cmd_ch ();
	prd_res_if res_ch ();

	pattern_run_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	cmd_beat_t pending[$];
	decoded_t  expected_decodes[$];
	int        accepted    = 0;
	int        total_items = 0;
	int        failures    = 0;
	int        noise_pct   = 0;
	int        hold_left   = 0;
	bit        hold_done   = 0;
	int        cycle_count = 0;

	// mirror of the decoder state
	phase_t     mirror_phase = PH_HEADER;
	logic [7:0] hdr_bytes[8];
	int         hdr_count = 0;
	int         rec_count = 0;
	int         rec_len   = 0;
	int         fill_pos  = 0;
	int         read_pos  = 0;
	int         reps_done = 0;
	logic [7:0] pattern_mem[BUF_DEPTH];

	// advance the mirror by one accepted beat and queue the result it causes
	function automatic void decode_beat(input bit command, input logic [7:0] data);
		decoded_t r;
		r.out_byte = 8'h00;
		r.last     = 1'b0;
		if (mirror_phase == PH_ERROR) begin
			r.status = ST_TOOLONG;
		end else if (mirror_phase == PH_ENDED) begin
			r.status = ST_END;
		end else if (command == CMD_PUSH) begin
			r.status = ST_ACCEPT;
			if (mirror_phase == PH_OUTPUT) begin
				r.status = ST_REFUSE;
			end else if (mirror_phase == PH_HEADER) begin
				hdr_bytes[hdr_count] = data;
				hdr_count++;
				if (hdr_count == 8) begin
					hdr_count = 0;
					rec_count = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
					rec_len   = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
					if (rec_count <= 0 && rec_len <= 0) begin
						mirror_phase = PH_ENDED;
						r.status = ST_END;
					end else if (rec_len > BUF_DEPTH) begin
						mirror_phase = PH_ERROR;
						r.status = ST_TOOLONG;
					end else if (rec_len > 0) begin
						fill_pos = 0;
						mirror_phase = PH_PATTERN;
					end
				end
			end else begin
				pattern_mem[fill_pos] = data;
				fill_pos++;
				if (fill_pos >= rec_len) begin
					read_pos  = 0;
					reps_done = 0;
					hdr_count = 0;
					mirror_phase = (rec_count > 0) ? PH_OUTPUT : PH_HEADER;
				end
			end
		end else if (mirror_phase != PH_OUTPUT) begin
			r.status = ST_NONE;
		end else begin
			r.out_byte = pattern_mem[read_pos];
			r.status   = ST_DELIVER;
			read_pos++;
			if (read_pos >= rec_len) begin
				read_pos = 0;
				reps_done++;
				if (reps_done >= rec_count) begin
					r.last    = 1'b1;
					reps_done = 0;
					hdr_count = 0;
					mirror_phase = PH_HEADER;
				end
			end
		end
		expected_decodes.push_back(r);
	endfunction

	function automatic void flag_error(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	function automatic int sender_idle_pct();
		if (accepted < total_items / 3)
			return 29;
		if (accepted < 2 * total_items / 3)
			return 58;
		return 0;
	endfunction

	function automatic int receiver_stall_pct();
		if (accepted < total_items / 3)
			return 58;
		if (accepted < 2 * total_items / 3)
			return 29;
		return 0;
	endfunction

	// stimulus builders
	task automatic push_item(input bit command, input logic [7:0] data);
		cmd_beat_t b;
		b.command     = command;
		b.stream_byte = data;
		pending.push_back(b);
	endtask

	task automatic noise_pull();
		if ($urandom_range(99) < noise_pct)
			push_item(CMD_PULL, 8'($urandom));
	endtask

	task automatic push_header(input int count, input int len);
		logic [63:0] raw;
		raw = {len, count};
		for (int i = 0; i < 8; i++) begin
			noise_pull();
			push_item(CMD_PUSH, raw[8*i +: 8]);
		end
	endtask

	// header, pattern body and pulls toward draining it (at most RUNAWAY_PULLS), with stray beats mixed in
	task automatic queue_record(input int count, input int len);
		longint pulls;
		push_header(count, len);
		for (int i = 0; i < len; i++) begin
			noise_pull();
			push_item(CMD_PUSH, 8'($urandom));
		end
		pulls = (count > 0 && len > 0) ? longint'(count) * len : 0;
		if (pulls > RUNAWAY_PULLS)
			pulls = RUNAWAY_PULLS;
		for (longint i = 0; i < pulls; i++) begin
			if ($urandom_range(99) < noise_pct)
				push_item(CMD_PUSH, 8'($urandom));
			push_item(CMD_PULL, 8'($urandom));
		end
	endtask

	function automatic int any_nonpositive();
		case ($urandom_range(3))
			0: return 0;
			1: return -1;
			2: return int'(32'h8000_0000);
			default: return int'($urandom | 32'h8000_0000);
		endcase
	endfunction

	task automatic build_stimulus();
		int pick, count, len, start;
		// directed: idle pull, extreme pattern bytes with a refused push,
		// empty length, empty count
		noise_pct = 0;
		push_item(CMD_PULL, 8'h00);
		push_header(2, 2);
		push_item(CMD_PUSH, 8'h00);
		push_item(CMD_PUSH, 8'hFF);
		push_item(CMD_PUSH, 8'h5A);
		repeat (4) push_item(CMD_PULL, 8'h00);
		push_header(3, -1);
		push_header(0, 1);
		push_item(CMD_PUSH, 8'h81);

		// random records, mostly well-formed, with a little noise
		noise_pct = 5;
		start     = pending.size();
		while (pending.size() - start < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len   = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
				count = (pick < 5 && len <= 2) ? $urandom_range(20, 5) : $urandom_range(4, 1);
			end else if (pick < 85) begin
				case ($urandom_range(3))
					0: count = 1;
					1: count = 32'h7FFF_FFFF;
					2: count = $urandom_range(1000, 1);
					default: count = int'($urandom & 32'h7FFF_FFFF) | 1;
				endcase
				len = any_nonpositive();
			end else begin
				count = any_nonpositive();
				len   = $urandom_range(8, 1);
			end
			queue_record(count, len);
		end

		// close the stream with one terminal record, then probe the final state
		case ($urandom_range(2))
			0: push_header(any_nonpositive(), any_nonpositive());
			1: begin
				case ($urandom_range(2))
					0: len = BUF_DEPTH + 1;
					1: len = 32'h7FFF_FFFF;
					default: len = $urandom_range(1 << 20, BUF_DEPTH + 2);
				endcase
				push_header(int'($urandom), len);
			end
			default: queue_record(32'h7FFF_FFFF, $urandom_range(4, 1));
		endcase
		repeat (STICKY_ITEMS) push_item(bit'($urandom_range(1)), 8'($urandom));
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset, stimulus and end of run
	initial begin
		arst_n = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.command     = CMD_PUSH;
		cmd_ch.stream_byte = 8'h00;
		res_ch.ready       = 1'b0;
		build_stimulus();
		total_items = pending.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0)
			@(posedge clk);
		while (expected_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// drive command beats; hold an offered beat until it is taken
	always @(posedge clk or negedge arst_n) begin : feed
		bit offer;
		if (!arst_n) begin
			cmd_ch.valid       <= 1'b0;
			cmd_ch.command     <= CMD_PUSH;
			cmd_ch.stream_byte <= 8'h00;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				decode_beat(cmd_ch.command, cmd_ch.stream_byte);
				void'(pending.pop_front());
				accepted <= accepted + 1;
			end
			if (!(cmd_ch.valid && !cmd_ch.ready)) begin
				offer = pending.size() != 0 && $urandom_range(99) >= sender_idle_pct();
				if (offer) begin
					cmd_ch.valid       <= 1'b1;
					cmd_ch.command     <= pending[0].command;
					cmd_ch.stream_byte <= pending[0].stream_byte;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off of the result side late in the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted >= (5 * total_items) / 6) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= hold_left == 0 && $urandom_range(99) >= receiver_stall_pct();
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : check
		decoded_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_decodes.size() == 0) begin
				flag_error($sformatf("result with nothing pending: byte %02h status %0d last %0b",
					res_ch.out_byte, res_ch.status, res_ch.last_of_record));
			end else begin
				want = expected_decodes.pop_front();
				if (res_ch.out_byte !== want.out_byte || res_ch.status !== want.status
						|| res_ch.last_of_record !== want.last)
					flag_error($sformatf(
						"mismatch: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
						want.out_byte, want.status, want.last,
						res_ch.out_byte, res_ch.status, res_ch.last_of_record));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
